>>> rtl/ddwc_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive wheel command package
// Shared types, register indexes and command codes of the wheel command block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddwc_pkg;

    // Depth of the queue between the classifier and the executor.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_TRACK  = 2'd0;
    localparam logic [1:0] CFG_PCT_PER_MPS = 2'd1;
    localparam logic [1:0] CFG_TURN_SPEED  = 2'd2;
    localparam logic [1:0] CFG_MIN_NONZERO = 2'd3;

    // Manual command codes; any other value is a plain stop.
    localparam logic [7:0] CMD_FORWARD = 8'd1;
    localparam logic [7:0] CMD_LEFT    = 8'd2;
    localparam logic [7:0] CMD_RIGHT   = 8'd3;
    localparam logic [7:0] CMD_HOLD    = 8'd4;
    localparam logic [7:0] CMD_RELEASE = 8'd5;

    // Wheel direction codes.
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Configuration registers as seen by the executor.
    typedef struct packed {
        logic [15:0] half_track;
        logic [15:0] pct_per_mps;
        logic [6:0]  turn_speed;
        logic [5:0]  min_nonzero;
    } t_cfg;

    // One classified item waiting in the queue.
    typedef struct packed {
        logic               is_path;
        logic [7:0]         cmd;
        logic [7:0]         speed;
        logic               empty;
        logic               near_zero;
        logic signed [15:0] wq;   // angular rate in 1/20480 rad/s, clamped
        logic signed [31:0] vq;   // linear rate in 1/(4096*20480) m/s units
    } t_item;

    // Executor states.
    typedef enum logic [1:0] {
        S_EXEC,
        S_LEFT,
        S_RIGHT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/ddwc_front.sv
// ----------------------------------------------------------------------------
// Wheel command front end
// Accepts input items and classifies them into queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddwc_front (
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_kind,
    input  wire logic [7:0]         i_manual_cmd,
    input  wire logic [7:0]         i_manual_speed,
    input  wire logic               i_path_empty,
    input  wire logic signed [15:0] i_lin_vel,
    input  wire logic signed [15:0] i_ang_vel,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output ddwc_pkg::t_item         o_q_item
);

    logic [16:0]        kv17;
    logic [16:0]        kw17;
    logic [16:0]        abs_v;
    logic [16:0]        abs_w;
    logic signed [16:0] kw2;
    logic signed [19:0] wq5;
    logic signed [15:0] wq;
    logic signed [18:0] kv5;

    // Ready whenever the queue has room; a valid item then transfers.
    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    // Magnitudes of both rates for the near-zero and small-turn tests.
    always_comb begin
        kv17  = {i_lin_vel[15], i_lin_vel};
        kw17  = {i_ang_vel[15], i_ang_vel};
        abs_v = kv17[16] ? (~kv17 + 17'd1) : kv17;
        abs_w = kw17[16] ? (~kw17 + 17'd1) : kw17;
    end

    // Small turn rates are doubled, then scaled by five and clamped to +-0.8.
    always_comb begin
        kw2 = (abs_w <= 17'd819) ? {i_ang_vel, 1'b0} : {i_ang_vel[15], i_ang_vel};
        wq5 = {{3{kw2[16]}}, kw2} + {kw2[16], kw2, 2'b00};
        if (wq5 > 20'sd16384) begin
            wq = 16'sd16384;
        end else if (wq5 < -20'sd16384) begin
            wq = -16'sd16384;
        end else begin
            wq = wq5[15:0];
        end
        kv5 = {{3{i_lin_vel[15]}}, i_lin_vel} + {i_lin_vel[15], i_lin_vel, 2'b00};
    end

    // Queue entry.
    always_comb begin
        o_q_item.is_path   = i_kind;
        o_q_item.cmd       = i_manual_cmd;
        o_q_item.speed     = i_manual_speed;
        o_q_item.empty     = i_path_empty;
        o_q_item.near_zero = (abs_v <= 17'd40) && (abs_w <= 17'd40);
        o_q_item.wq        = wq;
        o_q_item.vq        = {kv5[18], kv5, 12'b0};
    end

endmodule

`default_nettype wire

>>> rtl/ddwc_queue.sv
// ----------------------------------------------------------------------------
// Wheel command item queue
// Small first-in first-out buffer between the front end and the executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddwc_queue #(
    parameter int DEPTH = ddwc_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ddwc_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_not_empty,
    output ddwc_pkg::t_item      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    ddwc_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full      = (r_count == FULL);
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/ddwc_back.sv
// ----------------------------------------------------------------------------
// Wheel command executor
// Runs queued items against the command state and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddwc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ddwc_pkg::t_cfg  i_cfg,
    input  wire logic            i_q_not_empty,
    input  wire ddwc_pkg::t_item i_q_head,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [1:0]           o_left_dir,
    output logic [7:0]           o_left_speed,
    output logic [1:0]           o_right_dir,
    output logic [7:0]           o_right_speed
);

    // Half a percent in wheel units of 1/(5*2^32) percent.
    localparam logic [47:0] DEADBAND = 48'h2_8000_0000;

    typedef struct packed {
        logic [1:0] dir;
        logic [7:0] spd;
    } t_wheel;

    // Encode a wheel value N/(5*2^32) percent into direction and speed.
    // The whole percent is floor(floor(|N|/2^32)/5); below 300 the divide
    // by five is a multiply by 205/1024, exact over that range.
    function automatic t_wheel encode_wheel(input logic [47:0] n, input logic [5:0] min_pct);
        logic [47:0] mag;
        logic [15:0] q;
        logic [16:0] t;
        logic [6:0]  whole;
        t_wheel      w;
        mag = n[47] ? (~n + 48'd1) : n;
        q   = mag[47:32];
        t   = {8'd0, q[8:0]} * 17'd205;
        if (q >= 16'd300) begin
            whole = 7'd60;
        end else begin
            whole = t[16:10];
        end
        if (whole < {1'b0, min_pct}) begin
            whole = {1'b0, min_pct};
        end
        if (whole > 7'd60) begin
            whole = 7'd60;
        end
        if (mag <= DEADBAND) begin
            w.dir = ddwc_pkg::DIR_STOP;
            w.spd = 8'd0;
        end else begin
            w.dir = n[47] ? ddwc_pkg::DIR_REV : ddwc_pkg::DIR_FWD;
            w.spd = {1'b0, whole};
        end
        return w;
    endfunction

    // Signed percent of an encoded wheel.
    function automatic logic [8:0] signed_pct(input t_wheel w);
        logic [8:0] s;
        case (w.dir)
            ddwc_pkg::DIR_FWD: s = {1'b0, w.spd};
            ddwc_pkg::DIR_REV: s = ~{1'b0, w.spd} + 9'd1;
            default:           s = 9'd0;
        endcase
        return s;
    endfunction

    ddwc_pkg::t_state   r_state, n_state;
    logic [8:0]         r_last_cmd, n_last_cmd;
    logic [8:0]         r_last_speed, n_last_speed;
    logic               r_hold, n_hold;
    logic signed [31:0] r_p, n_p;
    logic signed [31:0] r_vq, n_vq;
    logic [47:0]        r_nl, n_nl;
    logic [47:0]        r_nr, n_nr;
    t_wheel             r_lw, n_lw;
    logic               r_valid, n_valid;
    t_wheel             r_ow_l, n_ow_l;
    t_wheel             r_ow_r, n_ow_r;

    logic               out_free;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    t_wheel             enc_w;
    t_wheel             enc_r;
    logic [8:0]         pct_sum;
    logic [8:0]         pct_mean;
    logic               repeat_cmd;

    assign out_free = !r_valid || i_out_ready;

    // Shared multiplier: turn term first, then each wheel times the scale.
    always_comb begin
        case (r_state)
            ddwc_pkg::S_LEFT: begin
                mul_a = r_vq - r_p;
                mul_b = {1'b0, i_cfg.pct_per_mps};
            end
            ddwc_pkg::S_RIGHT: begin
                mul_a = r_vq + r_p;
                mul_b = {1'b0, i_cfg.pct_per_mps};
            end
            default: begin
                mul_a = {{16{i_q_head.wq[15]}}, i_q_head.wq};
                mul_b = {1'b0, i_cfg.half_track};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Wheel encoders and the mean of the two signed percents.
    always_comb begin
        enc_w    = encode_wheel(r_nl, i_cfg.min_nonzero);
        enc_r    = encode_wheel(r_nr, i_cfg.min_nonzero);
        pct_sum  = signed_pct(r_lw) + signed_pct(enc_r);
        pct_mean = (pct_sum + {8'd0, pct_sum[8]});
        pct_mean = {pct_mean[8], pct_mean[8:1]};
    end

    assign repeat_cmd = ({1'b0, i_q_head.cmd} == r_last_cmd) &&
                        ({1'b0, i_q_head.speed} == r_last_speed);

    // Next state, state updates and result register loads.
    always_comb begin
        n_state      = r_state;
        n_last_cmd   = r_last_cmd;
        n_last_speed = r_last_speed;
        n_hold       = r_hold;
        n_p          = r_p;
        n_vq         = r_vq;
        n_nl         = r_nl;
        n_nr         = r_nr;
        n_lw         = r_lw;
        n_valid      = r_valid && !i_out_ready;
        n_ow_l       = r_ow_l;
        n_ow_r       = r_ow_r;
        o_q_pop      = 1'b0;
        case (r_state)
            ddwc_pkg::S_EXEC: begin
                if (i_q_not_empty) begin
                    if (!i_q_head.is_path) begin
                        // Manual command; a repeat is dropped.
                        if (repeat_cmd) begin
                            o_q_pop = 1'b1;
                        end else if (out_free) begin
                            o_q_pop      = 1'b1;
                            n_valid      = 1'b1;
                            n_last_cmd   = {1'b0, i_q_head.cmd};
                            n_last_speed = 9'd0;
                            n_ow_l       = '{ddwc_pkg::DIR_STOP, 8'd0};
                            n_ow_r       = '{ddwc_pkg::DIR_STOP, 8'd0};
                            case (i_q_head.cmd)
                                ddwc_pkg::CMD_FORWARD: begin
                                    n_ow_l       = '{ddwc_pkg::DIR_FWD, i_q_head.speed};
                                    n_ow_r       = '{ddwc_pkg::DIR_FWD, i_q_head.speed};
                                    n_last_speed = {1'b0, i_q_head.speed};
                                end
                                ddwc_pkg::CMD_LEFT: begin
                                    n_ow_l = '{ddwc_pkg::DIR_REV, {1'b0, i_cfg.turn_speed}};
                                    n_ow_r = '{ddwc_pkg::DIR_FWD, {1'b0, i_cfg.turn_speed}};
                                end
                                ddwc_pkg::CMD_RIGHT: begin
                                    n_ow_l = '{ddwc_pkg::DIR_FWD, {1'b0, i_cfg.turn_speed}};
                                    n_ow_r = '{ddwc_pkg::DIR_REV, {1'b0, i_cfg.turn_speed}};
                                end
                                ddwc_pkg::CMD_HOLD: begin
                                    n_hold = 1'b1;
                                end
                                ddwc_pkg::CMD_RELEASE: begin
                                    n_hold = 1'b0;
                                end
                                default: begin
                                    n_hold = r_hold;
                                end
                            endcase
                        end
                    end else if (r_hold || i_q_head.empty) begin
                        // Path item blocked by hold or carrying no points.
                        o_q_pop = 1'b1;
                    end else if (i_q_head.near_zero) begin
                        if (out_free) begin
                            o_q_pop      = 1'b1;
                            n_valid      = 1'b1;
                            n_last_speed = 9'd0;
                            n_ow_l       = '{ddwc_pkg::DIR_STOP, 8'd0};
                            n_ow_r       = '{ddwc_pkg::DIR_STOP, 8'd0};
                        end
                    end else begin
                        // Start the wheel computation with the turn term.
                        o_q_pop = 1'b1;
                        n_p     = mul_p[31:0];
                        n_vq    = i_q_head.vq;
                        n_state = ddwc_pkg::S_LEFT;
                    end
                end
            end
            ddwc_pkg::S_LEFT: begin
                n_nl    = mul_p[47:0];
                n_state = ddwc_pkg::S_RIGHT;
            end
            ddwc_pkg::S_RIGHT: begin
                n_nr    = mul_p[47:0];
                n_lw    = enc_w;
                n_state = ddwc_pkg::S_EMIT;
            end
            ddwc_pkg::S_EMIT: begin
                if (out_free) begin
                    n_valid      = 1'b1;
                    n_ow_l       = r_lw;
                    n_ow_r       = enc_r;
                    n_last_speed = pct_mean;
                    n_state      = ddwc_pkg::S_EXEC;
                end
            end
            default: begin
                n_state = ddwc_pkg::S_EXEC;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ddwc_pkg::S_EXEC;
            r_last_cmd   <= 9'd511;
            r_last_speed <= 9'd0;
            r_hold       <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last_cmd   <= n_last_cmd;
            r_last_speed <= n_last_speed;
            r_hold       <= n_hold;
            r_valid      <= n_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_vq   <= n_vq;
        r_nl   <= n_nl;
        r_nr   <= n_nr;
        r_lw   <= n_lw;
        r_ow_l <= n_ow_l;
        r_ow_r <= n_ow_r;
    end

    assign o_out_valid   = r_valid;
    assign o_left_dir    = r_ow_l.dir;
    assign o_left_speed  = r_ow_l.spd;
    assign o_right_dir   = r_ow_r.dir;
    assign o_right_speed = r_ow_r.spd;

endmodule

`default_nettype wire

>>> rtl/diff_drive_wheel_command.sv
// ----------------------------------------------------------------------------
// Differential drive wheel command
// Turns manual commands and path velocity pairs into wheel direction and
// speed bytes for a two-wheel drive.
// ----------------------------------------------------------------------------
// Usage:
//   Input items transfer on i_in_valid and o_in_ready; each is a manual
//   command or a path pair of Q4.12 linear and angular rates. Items go into
//   a queue of QUEUE_DEPTH entries, so o_in_ready only drops when it is full.
//   Results transfer on o_out_valid and i_out_ready; an item gives one result
//   or none (repeated manual commands, held or empty path items give none).
//   A manual command or near-zero path item is handled in S_EXEC, which pops
//   it and loads its result into the output register. A moving path item
//   steps through S_EXEC, S_LEFT, S_RIGHT and S_EMIT, as the single shared
//   multiplier forms the turn term and then each wheel product in turn; its
//   result is loaded in S_EMIT; the next item waits in the queue until then.
//   When the receiver stalls the result stays in the output register, the
//   executor holds its next result and the queue takes items until full.
//   Reset empties the queue, clears hold and restores the register defaults.
//   Configuration writes on i_cfg_wen take effect on the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_wheel_command #(
    parameter int QUEUE_DEPTH = ddwc_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wen,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_kind,
    input  wire logic [7:0]         i_manual_cmd,
    input  wire logic [7:0]         i_manual_speed,
    input  wire logic               i_path_empty,
    input  wire logic signed [15:0] i_lin_vel,
    input  wire logic signed [15:0] i_ang_vel,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_left_dir,
    output logic [7:0]              o_left_speed,
    output logic [1:0]              o_right_dir,
    output logic [7:0]              o_right_speed
);

    ddwc_pkg::t_cfg  r_cfg;
    ddwc_pkg::t_item q_in;
    ddwc_pkg::t_item q_head;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_not_empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_track  <= 16'd410;
            r_cfg.pct_per_mps <= 16'd51200;
            r_cfg.turn_speed  <= 7'd30;
            r_cfg.min_nonzero <= 6'd10;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                ddwc_pkg::CFG_HALF_TRACK:  r_cfg.half_track  <= i_cfg_data;
                ddwc_pkg::CFG_PCT_PER_MPS: r_cfg.pct_per_mps <= i_cfg_data;
                ddwc_pkg::CFG_TURN_SPEED:  r_cfg.turn_speed  <= i_cfg_data[6:0];
                ddwc_pkg::CFG_MIN_NONZERO: r_cfg.min_nonzero <= i_cfg_data[5:0];
                default:                   r_cfg.half_track  <= r_cfg.half_track;
            endcase
        end
    end

    // Front end: accepts and classifies items.
    ddwc_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_manual_cmd   (i_manual_cmd),
        .i_manual_speed (i_manual_speed),
        .i_path_empty   (i_path_empty),
        .i_lin_vel      (i_lin_vel),
        .i_ang_vel      (i_ang_vel),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_item       (q_in)
    );

    // Queue between front end and executor.
    ddwc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_item      (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_head      (q_head)
    );

    // Executor with the command state and the result register.
    ddwc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_not_empty (q_not_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_dir    (o_left_dir),
        .o_left_speed  (o_left_speed),
        .o_right_dir   (o_right_dir),
        .o_right_speed (o_right_speed)
    );

endmodule

`default_nettype wire

>>> tb/tb_diff_drive_wheel_command.sv
// ----------------------------------------------------------------------------
// Differential drive wheel command testbench
// Drives manual commands and path velocity pairs through the valid/ready
// input channel, predicts each wheel command with an independent model of
// the block, and compares every output transfer against the oldest pending
// prediction. Several register settings are visited, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_diff_drive_wheel_command;

    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Random items per register setting.
    localparam int ITEMS_PER_PHASE = 80;
    localparam int NUM_PHASES = 5;
    // Cycles left for items that give no result to pass through the block.
    localparam int SETTLE_CYCLES = 20;

    // One input item as driven on the payload ports.
    typedef struct packed {
        logic               kind;
        logic [7:0]         cmd;
        logic [7:0]         speed;
        logic               empty;
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } t_drive_item;

    // One wheel command as seen on the result ports.
    typedef struct packed {
        logic [1:0] left_dir;
        logic [7:0] left_speed;
        logic [1:0] right_dir;
        logic [7:0] right_speed;
    } t_wheel_cmd;

    // Wheel percents are N / (5 * 2^32).
    localparam longint PCT_DEN = 64'sd5 * (64'sd1 <<< 32);

    // ------------------------------------------------------------------------
    // Scoreboard: predicts wheel commands and checks the block's results.
    // ------------------------------------------------------------------------
    class wheel_command_scoreboard;
        int          errors;
        t_wheel_cmd  pending_cmds[$];
        int          half_track;
        int          pct_per_mps;
        logic [6:0]  turn_speed;
        int          min_nonzero;
        int          last_cmd;
        int          last_speed;
        bit          hold;

        function new();
            errors = 0;
            half_track = 410;
            pct_per_mps = 51200;
            turn_speed = 7'd30;
            min_nonzero = 10;
            last_cmd = 511;
            last_speed = 0;
            hold = 1'b0;
        endfunction

        function void set_config(int ht, int ppm, logic [6:0] ts, int mn);
            half_track = ht;
            pct_per_mps = ppm;
            turn_speed = ts;
            min_nonzero = mn;
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction

        // Clamp a wheel percent, apply the deadband and the minimum speed.
        function void encode_wheel(longint n, output logic [1:0] dir,
                                   output logic [7:0] spd);
            longint mag;
            longint whole;
            if (n > 60 * PCT_DEN) n = 60 * PCT_DEN;
            if (n < -60 * PCT_DEN) n = -60 * PCT_DEN;
            mag = (n < 0) ? -n : n;
            if (mag * 2 <= PCT_DEN) begin
                dir = ddwc_pkg::DIR_STOP;
                spd = 8'd0;
            end else begin
                whole = mag / PCT_DEN;
                if (whole < min_nonzero) whole = min_nonzero;
                if (whole > 60) whole = 60;
                dir = (n > 0) ? ddwc_pkg::DIR_FWD : ddwc_pkg::DIR_REV;
                spd = whole[7:0];
            end
        endfunction

        function int signed_pct(logic [1:0] dir, logic [7:0] spd);
            if (dir == ddwc_pkg::DIR_FWD) return int'(spd);
            if (dir == ddwc_pkg::DIR_REV) return -int'(spd);
            return 0;
        endfunction

        // Note an accepted input item and queue the command it causes.
        function void note_item(t_drive_item it);
            t_wheel_cmd r;
            int kv;
            int kw;
            longint wq;
            longint vq;
            r = '0;
            if (!it.kind) begin
                // A manual command repeating the last command and speed is dropped.
                if (int'(it.cmd) == last_cmd && int'(it.speed) == last_speed) return;
                last_speed = 0;
                case (it.cmd)
                    ddwc_pkg::CMD_FORWARD: begin
                        r = '{ddwc_pkg::DIR_FWD, it.speed, ddwc_pkg::DIR_FWD, it.speed};
                        last_speed = int'(it.speed);
                    end
                    ddwc_pkg::CMD_LEFT: begin
                        r = '{ddwc_pkg::DIR_REV, {1'b0, turn_speed},
                              ddwc_pkg::DIR_FWD, {1'b0, turn_speed}};
                    end
                    ddwc_pkg::CMD_RIGHT: begin
                        r = '{ddwc_pkg::DIR_FWD, {1'b0, turn_speed},
                              ddwc_pkg::DIR_REV, {1'b0, turn_speed}};
                    end
                    ddwc_pkg::CMD_HOLD: hold = 1'b1;
                    ddwc_pkg::CMD_RELEASE: hold = 1'b0;
                    default: ;
                endcase
                last_cmd = int'(it.cmd);
                pending_cmds.push_back(r);
                return;
            end
            // Path items are ignored while held or when they carry no points.
            if (hold || it.empty) return;
            kv = int'($signed(it.lin));
            kw = int'($signed(it.ang));
            if ((kv < 0 ? -kv : kv) <= 40 && (kw < 0 ? -kw : kw) <= 40) begin
                last_speed = 0;
                pending_cmds.push_back(r);
                return;
            end
            // Small turn rates are doubled, then the rate is clamped to 0.8.
            if ((kw < 0 ? -kw : kw) <= 819) kw = kw * 2;
            wq = longint'(kw) * 5;
            if (wq > 16384) wq = 16384;
            if (wq < -16384) wq = -16384;
            vq = longint'(kv) * 20480;
            encode_wheel((vq - wq * half_track) * pct_per_mps, r.left_dir, r.left_speed);
            encode_wheel((vq + wq * half_track) * pct_per_mps, r.right_dir, r.right_speed);
            last_speed = (signed_pct(r.left_dir, r.left_speed)
                          + signed_pct(r.right_dir, r.right_speed)) / 2;
            pending_cmds.push_back(r);
        endfunction

        // Compare a result transfer with the oldest pending command.
        function void check_command(t_wheel_cmd got);
            t_wheel_cmd exp;
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ld=%0d ls=%0d rd=%0d rs=%0d",
                         $time, got.left_dir, got.left_speed, got.right_dir,
                         got.right_speed);
                errors++;
                return;
            end
            exp = pending_cmds.pop_front();
            if (got.left_dir !== exp.left_dir || got.left_speed !== exp.left_speed ||
                got.right_dir !== exp.right_dir || got.right_speed !== exp.right_speed) begin
                $display("%0t: mismatch expected ld=%0d ls=%0d rd=%0d rs=%0d, %s",
                         $time, exp.left_dir, exp.left_speed, exp.right_dir,
                         exp.right_speed, "actual");
                $display("    ld=%0d ls=%0d rd=%0d rs=%0d",
                         got.left_dir, got.left_speed, got.right_dir, got.right_speed);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wen = 1'b0;
    logic [1:0]         i_cfg_index = ddwc_pkg::CFG_HALF_TRACK;
    logic [15:0]        i_cfg_data = 16'd0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = 1'b0;
    logic [7:0]         i_manual_cmd = 8'd0;
    logic [7:0]         i_manual_speed = 8'd0;
    logic               i_path_empty = 1'b0;
    logic signed [15:0] i_lin_vel = 16'sd0;
    logic signed [15:0] i_ang_vel = 16'sd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_left_dir;
    logic [7:0]         o_left_speed;
    logic [1:0]         o_right_dir;
    logic [7:0]         o_right_speed;

    diff_drive_wheel_command dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_manual_cmd  (i_manual_cmd),
        .i_manual_speed(i_manual_speed),
        .i_path_empty  (i_path_empty),
        .i_lin_vel     (i_lin_vel),
        .i_ang_vel     (i_ang_vel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_dir    (o_left_dir),
        .o_left_speed  (o_left_speed),
        .o_right_dir   (o_right_dir),
        .o_right_speed (o_right_speed)
    );

    wheel_command_scoreboard sb = new();
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    t_drive_item last_manual = '0;

    // Clock generation.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic t_drive_item manual_item(logic [7:0] cmd, logic [7:0] spd);
        t_drive_item it;
        it.kind = 1'b0;
        it.cmd = cmd;
        it.speed = spd;
        // Path fields carry noise; the block must ignore them.
        it.empty = 1'($urandom_range(0, 1));
        it.lin = 16'($urandom);
        it.ang = 16'($urandom);
        return it;
    endfunction

    function automatic t_drive_item path_item(logic empty, int v, int w);
        t_drive_item it;
        it.kind = 1'b1;
        it.cmd = 8'($urandom);
        it.speed = 8'($urandom);
        it.empty = empty;
        it.lin = 16'(v);
        it.ang = 16'(w);
        return it;
    endfunction

    // Velocity drawn mostly from the useful range, sometimes anywhere.
    function automatic int rand_vel(int span);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return int'($signed(16'($urandom)));
        if (sel == 1) return int'($urandom_range(0, 120)) - 60;
        if (sel < 4) return int'($urandom_range(0, 1800)) - 900;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_drive_item random_item();
        int sel;
        logic [7:0] cmd;
        logic [7:0] spd;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            sel = $urandom_range(0, 99);
            if (sel < 8 && last_manual.kind == 1'b0)
                return manual_item(last_manual.cmd, last_manual.speed);
            if (sel < 30) cmd = ddwc_pkg::CMD_FORWARD;
            else if (sel < 48) cmd = ddwc_pkg::CMD_LEFT;
            else if (sel < 66) cmd = ddwc_pkg::CMD_RIGHT;
            else if (sel < 74) cmd = ddwc_pkg::CMD_HOLD;
            else if (sel < 90) cmd = ddwc_pkg::CMD_RELEASE;
            else cmd = 8'($urandom);
            spd = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
            return manual_item(cmd, spd);
        end
        return path_item($urandom_range(0, 9) == 0, rand_vel(2500), rand_vel(5000));
    endfunction

    // Offer one item after a random gap and wait for its transfer.
    task automatic send_item(input t_drive_item it);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= it.kind;
        i_manual_cmd <= it.cmd;
        i_manual_speed <= it.speed;
        i_path_empty <= it.empty;
        i_lin_vel <= it.lin;
        i_ang_vel <= it.ang;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(it);
        if (!it.kind) last_manual = it;
    endtask

    // Let the block drain before the registers change.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_wen <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] ht, input logic [15:0] ppm,
                              input logic [6:0] ts, input logic [5:0] mn);
        write_reg(ddwc_pkg::CFG_HALF_TRACK, ht);
        write_reg(ddwc_pkg::CFG_PCT_PER_MPS, ppm);
        write_reg(ddwc_pkg::CFG_TURN_SPEED, {9'd0, ts});
        write_reg(ddwc_pkg::CFG_MIN_NONZERO, {10'd0, mn});
        i_cfg_wen <= 1'b0;
        sb.set_config(int'(ht), int'(ppm), ts, int'(mn));
    endtask

    // Short directed sequence at the reset register values.
    task automatic run_directed();
        send_item(manual_item(ddwc_pkg::CMD_FORWARD, 8'd0));
        send_item(manual_item(ddwc_pkg::CMD_FORWARD, 8'd0));
        send_item(manual_item(ddwc_pkg::CMD_FORWARD, 8'd255));
        send_item(manual_item(ddwc_pkg::CMD_LEFT, 8'd7));
        send_item(manual_item(ddwc_pkg::CMD_RIGHT, 8'd200));
        send_item(manual_item(ddwc_pkg::CMD_HOLD, 8'd0));
        send_item(path_item(1'b0, 2048, 0));
        send_item(manual_item(ddwc_pkg::CMD_RELEASE, 8'd0));
        send_item(manual_item(8'd0, 8'd0));
        send_item(manual_item(8'd255, 8'd255));
        send_item(manual_item(8'd6, 8'd6));
        send_item(path_item(1'b1, 2048, 1000));
        send_item(path_item(1'b0, 40, -40));
        send_item(path_item(1'b0, 41, 0));
        send_item(path_item(1'b0, 32767, 0));
        send_item(path_item(1'b0, -32768, -32768));
        send_item(path_item(1'b0, 0, 819));
        send_item(path_item(1'b0, 0, 820));
        send_item(path_item(1'b0, 0, -32768));
        send_item(path_item(1'b0, 1228, 2000));
        send_item(path_item(1'b0, -600, 300));
        // A near-zero path clears the speed, so this repeat of the last
        // manual stop with speed zero is dropped.
        send_item(path_item(1'b0, 10, 10));
        send_item(manual_item(8'd6, 8'd0));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, then check each transfer.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        t_wheel_cmd got;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) recv_burst = ~recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got = '{o_left_dir, o_left_speed, o_right_dir, o_right_speed};
            sb.check_command(got);
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("diff_drive_wheel_command test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed items, then random phases per setting.
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: write_regs(16'd0, 16'hFFFF, 7'd127, 6'd63);
                    2: write_regs(16'hFFFF, 16'd0, 7'd0, 6'd0);
                    3: write_regs(16'($urandom), 16'($urandom),
                                  7'($urandom_range(0, 100)),
                                  6'($urandom_range(0, 60)));
                    default: write_regs(16'd410, 16'd51200, 7'd30, 6'd10);
                endcase
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) send_burst = ($urandom_range(0, 2) == 0);
                send_item(random_item());
            end
        end
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("diff_drive_wheel_command test passed");
        end else begin
            $display("diff_drive_wheel_command test failed");
        end
        $finish;
    end

endmodule
